// File: hw/rtl/optimum_size_search_controller_core_macros.svh
// Assertion macros shared by the optimum size search controller RTL.
`ifndef OPTIMUM_SIZE_SEARCH_CONTROLLER_CORE_MACROS_SVH
`define OPTIMUM_SIZE_SEARCH_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define OSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("osc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define OSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("osc assertion failed");

`endif

// File: hw/rtl/osc_pkg.sv
// Shared types and constants of the optimum size search controller.
`default_nettype none
package osc_pkg;
    localparam int COST_BITS     = 48;
    localparam int SUM_BITS      = 52;
    localparam int DIV_BITS      = 52;
    localparam int REM_BITS      = 40;
    localparam int ALLOC_BITS    = 40;
    localparam int STEP_BITS     = 6;
    localparam int FACTOR_BITS   = 16;
    localparam int TOL_BITS      = 16;
    localparam int CNT_BITS      = 4;
    localparam int CFG_BITS      = 24;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [FACTOR_BITS-1:0] FACTOR_START = 16'd8192;
    localparam logic [FACTOR_BITS-1:0] FACTOR_MAX   = 16'hFFFF;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REFINE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_SIZE = 2'd3;

    // Search phases.
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_FAST  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_HIGH  = 2'd3;

    // Point slots.
    localparam int PT_LAST  = 0;
    localparam int PT_LAST2 = 1;
    localparam int PT_MID   = 2;
    localparam int PT_BOT   = 3;
    localparam int PT_TOP   = 4;
    localparam int PT_NUM   = 5;

    typedef struct packed {
        logic                 start;
        logic [STEP_BITS-1:0] steps;
    } t_div_cmd;
endpackage
`default_nettype wire

// File: hw/rtl/osc_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module osc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  osc_pkg::t_div_cmd           i_cmd,
    input  logic [osc_pkg::DIV_BITS-1:0] i_dividend,
    input  logic [osc_pkg::REM_BITS-1:0] i_rem_init,
    input  logic [osc_pkg::REM_BITS-1:0] i_divisor,
    output logic                        o_done,
    output logic [osc_pkg::DIV_BITS-1:0] o_quot
);
    import osc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_cnt;
    logic [DIV_BITS-1:0]  r_dvd;
    logic [DIV_BITS-1:0]  r_quot;
    logic [REM_BITS-1:0]  r_rem;
    logic [REM_BITS-1:0]  r_dsr;
    logic [REM_BITS:0]    trial;
    logic [REM_BITS:0]    diff;
    logic                 ge;

    // Shift in the next dividend bit and try a subtract.
    assign trial = {r_rem, r_dvd[DIV_BITS-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    // Control: count the steps and flag the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dvd  <= i_dividend;
            r_rem  <= i_rem_init;
            r_dsr  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DIV_BITS-2:0], 1'b0};
            r_rem  <= ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
            r_quot <= {r_quot[DIV_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// File: hw/rtl/optimum_size_search_controller_core.sv
// Top level of the optimum allocation-area size search controller.
// Use: one request per collection event on the input channel (valid/ready),
// carrying the major flag, interval start and end times and words allocated.
// Each request gives exactly one result on the output channel: new size,
// search phase and an optimum-found flag. Configuration is a plain write
// port (tolerance, refine factor, window length); the initial size index
// is taken but ignored; reset sets size 256 (all ones if SIZE_BITS <= 8).
// Path from acceptance to the output register: a major event goes straight
// to the output stage; a minor event with a saturated cost skips the divider,
// and any other minor event uses the divider for the cost per word. One that
// closes a window adds averaging in the same divider and then the search
// step, which may take the reciprocal of the factor in the divider; the next
// request may be taken one cycle later.
// One request is in work at a time; ready is high only while idle.
// The result sits in an output register; a new request may be taken while
// it waits, and the next result waits until the receiver takes the old one.
// Reset (synchronous, active low) restores registers and all search state.
`default_nettype none
`include "optimum_size_search_controller_core_macros.svh"
module optimum_size_search_controller_core #(
    parameter int SIZE_BITS      = 24,
    parameter int COST_FRAC_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_major_gc,
    input  logic [osc_pkg::COST_BITS-1:0]    i_interval_start,
    input  logic [osc_pkg::COST_BITS-1:0]    i_interval_end,
    input  logic [osc_pkg::ALLOC_BITS-1:0]   i_alloc_words,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [SIZE_BITS-1:0]             o_size_blocks,
    output logic [1:0]                       o_search_phase,
    output logic                             o_optimum_found,
    input  logic                             i_cfg_we,
    input  logic [osc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [osc_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import osc_pkg::*;

    localparam logic [SIZE_BITS-1:0] SIZE_MAX   = '1;
    localparam logic [SIZE_BITS-1:0] RESET_SIZE =
        (SIZE_BITS > 8) ? SIZE_BITS'(256) : SIZE_MAX;
    localparam int SHIFT_HI = COST_BITS - COST_FRAC_BITS;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_COST_CHK  = 4'd1;
    localparam logic [3:0] S_DIV_COST  = 4'd2;
    localparam logic [3:0] S_ACC       = 4'd3;
    localparam logic [3:0] S_DIV_AVG   = 4'd4;
    localparam logic [3:0] S_SEARCH    = 4'd5;
    localparam logic [3:0] S_TOL_MUL   = 4'd6;
    localparam logic [3:0] S_TOL_DEC   = 4'd7;
    localparam logic [3:0] S_DIV_RECIP = 4'd8;
    localparam logic [3:0] S_SCL_MUL   = 4'd9;
    localparam logic [3:0] S_SCL_FIN   = 4'd10;
    localparam logic [3:0] S_OUT       = 4'd11;

    logic [3:0]                   r_state;
    logic [TOL_BITS-1:0]          r_tol;
    logic [FACTOR_BITS-1:0]       r_refine;
    logic [CNT_BITS-1:0]          r_wlen;

    logic [COST_BITS-1:0]         r_el;
    logic [ALLOC_BITS-1:0]        r_alloc;
    logic [COST_BITS-1:0]         r_cost;
    logic [CNT_BITS-1:0]          r_cnt;
    logic [SUM_BITS-1:0]          r_sum;
    logic [SIZE_BITS-1:0]         r_cur;
    logic [1:0]                   r_phase;
    logic [FACTOR_BITS-1:0]       r_factor;
    logic                         r_found;
    logic [COST_BITS-1:0]         r_pc [PT_NUM];
    logic [SIZE_BITS-1:0]         r_ps [PT_NUM];

    logic [COST_BITS-1:0]         r_tol_top;
    logic [COST_BITS-1:0]         r_tol_bot;
    logic [COST_BITS+TOL_BITS-1:0] r_tol_prod;
    logic [COST_BITS-1:0]         r_tol_diff;
    logic [SIZE_BITS-1:0]         r_mul_s;
    logic [FACTOR_BITS-1:0]       r_mul_f;
    logic [SIZE_BITS+FACTOR_BITS-1:0] r_scl_prod;

    logic                         r_ovalid;
    logic [SIZE_BITS-1:0]         r_osize;
    logic [1:0]                   r_ophase;
    logic                         r_ofound;

    logic                         in_acc;
    logic [COST_BITS-1:0]         el_sub;
    logic [COST_BITS-1:0]         cost_hi;
    logic                         cost_sat;
    logic [CNT_BITS-1:0]          cnt_new;
    logic [SUM_BITS-1:0]          sum_new;
    logic                         win_full;
    logic                         tol_ok;
    logic                         recip_go;
    logic [FACTOR_BITS-1:0]       recip_val;
    logic [SIZE_BITS+FACTOR_BITS:0] scl_rnd;
    logic [SIZE_BITS+4:0]         scl_v;
    logic [SIZE_BITS-1:0]         scl_size;
    t_div_cmd                     div_cmd;
    logic [DIV_BITS-1:0]          div_dvd;
    logic [REM_BITS-1:0]          div_rem;
    logic [REM_BITS-1:0]          div_dsr;
    logic                         div_done;
    logic [DIV_BITS-1:0]          div_quot;

    // Midpoint of two sizes, rounded up, kept at least 1.
    function automatic logic [SIZE_BITS-1:0] f_mid(input logic [SIZE_BITS-1:0] a,
                                                   input logic [SIZE_BITS-1:0] b);
        logic [SIZE_BITS:0]   s;
        logic [SIZE_BITS-1:0] v;
        s = {1'b0, a} + {1'b0, b} + (SIZE_BITS+1)'(1);
        v = s[SIZE_BITS:1];
        return (v == '0) ? SIZE_BITS'(1) : v;
    endfunction

    assign in_acc   = i_valid && o_ready;
    assign el_sub   = i_interval_end - i_interval_start;
    assign cost_hi  = r_el >> SHIFT_HI;
    assign cost_sat = (cost_hi >= COST_BITS'(r_alloc));
    assign cnt_new  = r_cnt + 1'b1;
    assign sum_new  = r_sum + SUM_BITS'(r_cost);
    assign win_full = (cnt_new >= r_wlen) && (cnt_new != '0);
    assign tol_ok   = ({r_tol_diff, {TOL_BITS{1'b0}}} < r_tol_prod);
    assign recip_go = (r_state == S_SEARCH) && (r_phase == PH_FAST) &&
                      (r_pc[PT_LAST2] == '0) && (r_cost > r_pc[PT_LAST]) &&
                      (r_factor != '0);
    assign recip_val = (div_quot[DIV_BITS-1:FACTOR_BITS] != '0) ? FACTOR_MAX
                                                                 : div_quot[FACTOR_BITS-1:0];

    // Round the scaled size half up and clamp it to the size range.
    assign scl_rnd  = (SIZE_BITS+FACTOR_BITS+1)'(r_scl_prod) + (SIZE_BITS+FACTOR_BITS+1)'(2048);
    assign scl_v    = scl_rnd[SIZE_BITS+FACTOR_BITS:12];
    assign scl_size = (scl_v == '0) ? SIZE_BITS'(1) :
                      (scl_v > (SIZE_BITS+5)'(SIZE_MAX)) ? SIZE_MAX : scl_v[SIZE_BITS-1:0];

    // Launch the shared divider for cost, average or reciprocal.
    always_comb begin
        div_cmd = '0;
        div_dvd = '0;
        div_rem = '0;
        div_dsr = '0;
        if ((r_state == S_COST_CHK) && !cost_sat) begin
            div_cmd.start = 1'b1;
            div_cmd.steps = STEP_BITS'(COST_BITS);
            div_dvd = {COST_BITS'(r_el << COST_FRAC_BITS), {(DIV_BITS-COST_BITS){1'b0}}};
            div_rem = cost_hi[REM_BITS-1:0];
            div_dsr = r_alloc;
        end else if ((r_state == S_ACC) && win_full) begin
            div_cmd.start = 1'b1;
            div_cmd.steps = STEP_BITS'(SUM_BITS);
            div_dvd = sum_new;
            div_dsr = REM_BITS'(cnt_new);
        end else if (recip_go) begin
            div_cmd.start = 1'b1;
            div_cmd.steps = STEP_BITS'(25);
            div_dvd = {25'(25'h1000000 + 25'(r_factor >> 1)), {(DIV_BITS-25){1'b0}}};
            div_dsr = REM_BITS'(r_factor);
        end
    end

    osc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .i_dividend (div_dvd),
        .i_rem_init (div_rem),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= 16'd6554;
            r_refine <= 16'd5120;
            r_wlen   <= 4'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOLERANCE: r_tol    <= i_cfg_data[TOL_BITS-1:0];
                CFG_REFINE:    r_refine <= i_cfg_data[FACTOR_BITS-1:0];
                CFG_WINDOW:    r_wlen   <= i_cfg_data[CNT_BITS-1:0];
                CFG_INIT_SIZE: r_wlen   <= r_wlen;
                default:       r_wlen   <= r_wlen;
            endcase
        end
    end

    // Sequencer and search state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_cur    <= RESET_SIZE;
            r_phase  <= PH_START;
            r_factor <= FACTOR_START;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < PT_NUM; k++) begin
                r_pc[k] <= '0;
                r_ps[k] <= '0;
            end
        end else begin
            // Drop the output once taken; a reload below overrides.
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_found <= 1'b0;
                        r_el    <= (i_interval_end >= i_interval_start) ? el_sub : '0;
                        r_alloc <= (i_alloc_words == '0) ? ALLOC_BITS'(1) : i_alloc_words;
                        r_state <= i_major_gc ? S_OUT : S_COST_CHK;
                    end
                end
                S_COST_CHK: begin
                    if (cost_sat) begin
                        r_cost  <= '1;
                        r_state <= S_ACC;
                    end else begin
                        r_state <= S_DIV_COST;
                    end
                end
                S_DIV_COST: begin
                    if (div_done) begin
                        r_cost  <= div_quot[COST_BITS-1:0];
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_cnt   <= cnt_new;
                    r_sum   <= sum_new;
                    r_state <= win_full ? S_DIV_AVG : S_OUT;
                end
                S_DIV_AVG: begin
                    if (div_done) begin
                        r_cost  <= div_quot[COST_BITS-1:0];
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    case (r_phase)
                        PH_START: begin
                            r_tol_top <= r_pc[PT_LAST];
                            r_tol_bot <= r_cost;
                            r_state   <= S_TOL_MUL;
                        end
                        PH_FAST: begin
                            if ((r_pc[PT_LAST2] == '0) && (r_cost > r_pc[PT_LAST])) begin
                                // Wrong direction: flip the factor once.
                                r_pc[PT_LAST2] <= r_cost;
                                r_ps[PT_LAST2] <= r_cur;
                                if (r_factor == '0) begin
                                    r_factor <= FACTOR_MAX;
                                    r_mul_s  <= r_ps[PT_LAST];
                                    r_mul_f  <= FACTOR_MAX;
                                    r_state  <= S_SCL_MUL;
                                end else begin
                                    r_state  <= S_DIV_RECIP;
                                end
                            end else if (r_cost < r_pc[PT_LAST]) begin
                                r_pc[PT_LAST2] <= r_pc[PT_LAST];
                                r_ps[PT_LAST2] <= r_ps[PT_LAST];
                                r_pc[PT_LAST]  <= r_cost;
                                r_ps[PT_LAST]  <= r_cur;
                                r_mul_s        <= r_cur;
                                r_mul_f        <= r_factor;
                                r_state        <= S_SCL_MUL;
                            end else begin
                                // Form the top/middle/bottom bracket.
                                r_pc[PT_TOP] <= r_pc[PT_LAST2];
                                r_ps[PT_TOP] <= r_ps[PT_LAST2];
                                r_pc[PT_MID] <= r_pc[PT_LAST];
                                r_ps[PT_MID] <= r_ps[PT_LAST];
                                r_pc[PT_BOT] <= r_cost;
                                r_ps[PT_BOT] <= r_cur;
                                r_tol_top    <= r_pc[PT_LAST2];
                                r_tol_bot    <= r_cost;
                                r_state      <= S_TOL_MUL;
                            end
                        end
                        PH_LOW: begin
                            if (r_cost < r_pc[PT_MID]) begin
                                r_pc[PT_TOP] <= r_pc[PT_MID];
                                r_ps[PT_TOP] <= r_ps[PT_MID];
                                r_pc[PT_MID] <= r_cost;
                                r_ps[PT_MID] <= r_cur;
                                r_tol_top    <= r_pc[PT_MID];
                                r_tol_bot    <= r_pc[PT_BOT];
                                r_state      <= S_TOL_MUL;
                            end else begin
                                r_pc[PT_LAST] <= r_cost;
                                r_ps[PT_LAST] <= r_cur;
                                r_cur         <= f_mid(r_ps[PT_TOP], r_ps[PT_MID]);
                                r_phase       <= PH_HIGH;
                                r_state       <= S_OUT;
                            end
                        end
                        default: begin
                            if (r_cost < r_pc[PT_MID]) begin
                                r_pc[PT_BOT] <= r_pc[PT_MID];
                                r_ps[PT_BOT] <= r_ps[PT_MID];
                                r_pc[PT_MID] <= r_cost;
                                r_ps[PT_MID] <= r_cur;
                                r_tol_top    <= r_pc[PT_TOP];
                                r_tol_bot    <= r_pc[PT_MID];
                            end else begin
                                r_pc[PT_TOP] <= r_cost;
                                r_ps[PT_TOP] <= r_cur;
                                r_pc[PT_BOT] <= r_pc[PT_LAST];
                                r_ps[PT_BOT] <= r_ps[PT_LAST];
                                r_tol_top    <= r_cost;
                                r_tol_bot    <= r_pc[PT_LAST];
                            end
                            r_state <= S_TOL_MUL;
                        end
                    endcase
                end
                S_DIV_RECIP: begin
                    if (div_done) begin
                        r_factor <= recip_val;
                        r_mul_s  <= r_ps[PT_LAST];
                        r_mul_f  <= recip_val;
                        r_state  <= S_SCL_MUL;
                    end
                end
                S_TOL_MUL: begin
                    r_tol_prod <= (COST_BITS+TOL_BITS)'(r_tol) *
                                  (COST_BITS+TOL_BITS)'(r_tol_top);
                    r_tol_diff <= (r_tol_top > r_tol_bot) ? (r_tol_top - r_tol_bot)
                                                          : (r_tol_bot - r_tol_top);
                    r_state    <= S_TOL_DEC;
                end
                S_TOL_DEC: begin
                    if (r_phase == PH_START) begin
                        if (tol_ok) begin
                            r_factor <= r_refine;
                            r_found  <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_pc[PT_LAST]  <= r_cost;
                            r_ps[PT_LAST]  <= r_cur;
                            r_pc[PT_LAST2] <= '0;
                            r_mul_s        <= r_cur;
                            r_mul_f        <= r_factor;
                            r_phase        <= PH_FAST;
                            r_state        <= S_SCL_MUL;
                        end
                    end else if (tol_ok) begin
                        // Settle on the middle point.
                        r_pc[PT_LAST] <= r_pc[PT_MID];
                        r_ps[PT_LAST] <= r_ps[PT_MID];
                        r_cur         <= r_ps[PT_MID];
                        r_factor      <= r_refine;
                        r_phase       <= PH_START;
                        r_found       <= 1'b1;
                        r_state       <= S_OUT;
                    end else begin
                        r_cur   <= f_mid(r_ps[PT_MID], r_ps[PT_BOT]);
                        r_phase <= PH_LOW;
                        r_state <= S_OUT;
                    end
                end
                S_SCL_MUL: begin
                    r_scl_prod <= (SIZE_BITS+FACTOR_BITS)'(r_mul_s) *
                                  (SIZE_BITS+FACTOR_BITS)'(r_mul_f);
                    r_state    <= S_SCL_FIN;
                end
                S_SCL_FIN: begin
                    r_cur   <= scl_size;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_osize  <= r_cur;
                        r_ophase <= r_phase;
                        r_ofound <= r_found;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_size_blocks   = r_osize;
    assign o_search_phase  = r_ophase;
    assign o_optimum_found = r_ofound;

    `OSC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_ready)
    `OSC_ASSERT_IMP(a_found_restarts, i_clk, i_rst_n, o_valid && o_optimum_found, o_search_phase == PH_START)
    `OSC_ASSERT_IMP(a_size_nonzero, i_clk, i_rst_n, o_valid, o_size_blocks != '0)
    `OSC_ASSERT_IMP(a_div_idle_start, i_clk, i_rst_n, div_cmd.start, r_state == S_COST_CHK || r_state == S_ACC || r_state == S_SEARCH)
endmodule
`default_nettype wire
